@@ rtl/pffs_pkg.sv @@
// shared constants, types and helper functions of the point force field step
package pffs_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int DW          = 32;
	localparam int RW          = 31;
	localparam int MAG_W       = DW + 1;
	localparam int DSQ_W       = 2 * DW;
	localparam int SQ_W        = 2 * RW;
	localparam int PV_W        = DW + RW;
	localparam int DM_W        = PV_W - FRAC_BITS;
	localparam int EXT_W       = DM_W + 2;
	localparam int PROD_W      = RW + DW;
	localparam int NUM_W       = PROD_W + FRAC_BITS;
	localparam int Q_W         = DW - 1;
	localparam int DIV_STAGES  = Q_W + 1;
	localparam int SQRT_STAGES = DSQ_W / 2;
	localparam int ROOT_W      = DSQ_W / 2;
	localparam int NEAR_RAW    = 2 * FRAC_BITS - 23;
	localparam int NEAR_SH     = (NEAR_RAW < 0) ? 0 : NEAR_RAW;
	localparam int FIFO_DEPTH  = 8;

	localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SAT_NEG = {1'b1, {(DW-1){1'b0}}};
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [RW-1:0] RADIUS_RESET = RW'(ONE);

	typedef enum logic [2:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_FIELD_RADIUS,
		REG_FIELD_FORCE,
		REG_NONLINEAR_MODE,
		REG_LINEAR_DRAG,
		REG_ANGULAR_DRAG,
		REG_FRAME_TIME
	} reg_idx_t;

	typedef struct packed {
		logic signed [DW-1:0] center_x;
		logic signed [DW-1:0] center_y;
		logic        [RW-1:0] field_radius;
		logic signed [DW-1:0] field_force;
		logic                 nonlinear_mode;
		logic signed [DW-1:0] linear_drag_coef;
		logic signed [DW-1:0] angular_drag_coef;
		logic        [RW-1:0] frame_time;
	} cfg_t;

	typedef struct packed {
		logic                 affected;
		logic                 neg_x;
		logic                 neg_y;
		logic signed [DW-1:0] vel_x;
		logic signed [DW-1:0] vel_y;
		logic signed [DW-1:0] vel_a;
	} side_t;

	typedef struct packed {
		side_t                side;
		logic                 mode;
		logic [RW-1:0]        ax;
		logic [RW-1:0]        ay;
		logic [DSQ_W-1:0]     dsq;
		logic [RW-1:0]        q;
		logic [DW-1:0]        fm;
	} item_t;

	function automatic logic [DW-1:0] sat_dw(input logic signed [EXT_W-1:0] x);
		logic [DW-1:0] r;
		if (x > $signed(EXT_W'(SAT_POS)))
			r = SAT_POS;
		else if (x < $signed({{(EXT_W-DW){1'b1}}, SAT_NEG}))
			r = SAT_NEG;
		else
			r = x[DW-1:0];
		return r;
	endfunction

	function automatic logic [DW-1:0] abs_dw(input logic signed [DW-1:0] v);
		logic [DW-1:0] r;
		r = v[DW-1] ? DW'(-v) : DW'(v);
		return r;
	endfunction

	function automatic logic [RW-1:0] drag_k(input logic signed [DW-1:0] coef,
		input logic [RW-1:0] ft);
		logic [FRAC_BITS:0]    c;
		logic [FRAC_BITS+RW:0] p;
		if (coef[DW-1])
			c = '0;
		else if (coef > $signed(DW'(ONE)))
			c = ONE;
		else
			c = coef[FRAC_BITS:0];
		p = c * ft;
		return p[FRAC_BITS +: RW];
	endfunction

endpackage

@@ rtl/pffs_fifo.sv @@
// short queue of classified items between the front and back parts
module pffs_fifo #(
	parameter int DEPTH = pffs_pkg::FIFO_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  pffs_pkg::item_t              push_item,
	input  logic                         pop,
	output pffs_pkg::item_t              head,
	output logic                         head_valid,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	import pffs_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && count_q == CW'(DEPTH)))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue underflow");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count mismatch");

endmodule

@@ rtl/pffs_front.sv @@
// front part: accepts bodies, classifies them, computes distance and drag
module pffs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pffs_pkg::cfg_t                cfg,
	input  logic                          in_fire,
	input  logic signed [pffs_pkg::DW-1:0] body_x,
	input  logic signed [pffs_pkg::DW-1:0] body_y,
	input  logic signed [pffs_pkg::DW-1:0] lin_vel_x,
	input  logic signed [pffs_pkg::DW-1:0] lin_vel_y,
	input  logic signed [pffs_pkg::DW-1:0] ang_vel,
	input  logic                          is_static,
	input  logic                          is_tracked,
	output logic                          push,
	output pffs_pkg::item_t               push_item,
	output logic [1:0]                    inflight
);
	import pffs_pkg::*;

	function automatic logic signed [DW-1:0] drag_apply(input logic signed [DW-1:0] v,
		input logic [PV_W-1:0] pv, input logic k_on);
		logic signed [EXT_W-1:0] ve, de, r;
		ve = EXT_W'(v);
		de = $signed(EXT_W'(pv[FRAC_BITS +: DM_W]));
		r  = v[DW-1] ? ve + de : ve - de;
		return k_on ? $signed(sat_dw(r)) : v;
	endfunction

	logic signed [MAG_W-1:0] dx, dy;
	logic                    v_s1, v_s2, v_s3;

	logic                    dxneg_s1, dyneg_s1, skip_s1, fneg_s1, mode_s1;
	logic [MAG_W-1:0]        ax_s1, ay_s1;
	logic signed [DW-1:0]    vx_s1, vy_s1, va_s1;
	logic [DW-1:0]           fm_s1;
	logic [RW-1:0]           kl_s1, ka_s1;

	logic                    dxneg_s2, dyneg_s2, skip_s2, fneg_s2, mode_s2, box_s2;
	logic                    klon_s2, kaon_s2;
	logic [RW-1:0]           ax_s2, ay_s2;
	logic [SQ_W-1:0]         sqx_s2, sqy_s2, rsq_s2;
	logic [DSQ_W-1:0]        fsq_s2;
	logic [PV_W-1:0]         pvx_s2, pvy_s2, pva_s2;
	logic signed [DW-1:0]    vx_s2, vy_s2, va_s2;
	logic [DW-1:0]           fm_s2;

	logic [DSQ_W-1:0]        dsq;
	logic                    aff;
	item_t                   item_s3;

	assign dx = MAG_W'(cfg.center_x) - MAG_W'(body_x);
	assign dy = MAG_W'(cfg.center_y) - MAG_W'(body_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dxneg_s1 <= dx[MAG_W-1];
		dyneg_s1 <= dy[MAG_W-1];
		ax_s1    <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
		ay_s1    <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
		vx_s1    <= lin_vel_x;
		vy_s1    <= lin_vel_y;
		va_s1    <= ang_vel;
		skip_s1  <= is_static || is_tracked || (cfg.field_force == '0) ||
			(cfg.field_radius == '0);
		fm_s1    <= abs_dw(cfg.field_force);
		fneg_s1  <= cfg.field_force[DW-1];
		mode_s1  <= cfg.nonlinear_mode;
		kl_s1    <= drag_k(cfg.linear_drag_coef, cfg.frame_time);
		ka_s1    <= drag_k(cfg.angular_drag_coef, cfg.frame_time);
	end

	always_ff @(posedge clk) begin
		dxneg_s2 <= dxneg_s1;
		dyneg_s2 <= dyneg_s1;
		skip_s2  <= skip_s1;
		fneg_s2  <= fneg_s1;
		mode_s2  <= mode_s1;
		box_s2   <= (ax_s1 > MAG_W'(cfg.field_radius)) || (ay_s1 > MAG_W'(cfg.field_radius));
		ax_s2    <= ax_s1[RW-1:0];
		ay_s2    <= ay_s1[RW-1:0];
		sqx_s2   <= ax_s1[RW-1:0] * ax_s1[RW-1:0];
		sqy_s2   <= ay_s1[RW-1:0] * ay_s1[RW-1:0];
		rsq_s2   <= cfg.field_radius * cfg.field_radius;
		fsq_s2   <= fm_s1 * fm_s1;
		pvx_s2   <= abs_dw(vx_s1) * kl_s1;
		pvy_s2   <= abs_dw(vy_s1) * kl_s1;
		pva_s2   <= abs_dw(va_s1) * ka_s1;
		klon_s2  <= (kl_s1 != '0);
		kaon_s2  <= (ka_s1 != '0);
		vx_s2    <= vx_s1;
		vy_s2    <= vy_s1;
		va_s2    <= va_s1;
		fm_s2    <= fm_s1;
	end

	assign dsq = DSQ_W'(sqx_s2) + DSQ_W'(sqy_s2);
	assign aff = !skip_s2 && !box_s2 && !(dsq > DSQ_W'(rsq_s2)) &&
		((dsq >> NEAR_SH) != '0);

	always_ff @(posedge clk) begin
		item_s3.side.affected <= aff;
		item_s3.side.neg_x    <= dxneg_s2 != fneg_s2;
		item_s3.side.neg_y    <= dyneg_s2 != fneg_s2;
		item_s3.side.vel_x    <= drag_apply(vx_s2, pvx_s2, aff && klon_s2);
		item_s3.side.vel_y    <= drag_apply(vy_s2, pvy_s2, aff && klon_s2);
		item_s3.side.vel_a    <= drag_apply(va_s2, pva_s2, aff && kaon_s2);
		item_s3.mode          <= mode_s2;
		item_s3.ax            <= ax_s2;
		item_s3.ay            <= ay_s2;
		item_s3.dsq           <= dsq;
		item_s3.q             <= (|fsq_s2[DSQ_W-1:FRAC_BITS+RW]) ? '1 : fsq_s2[FRAC_BITS +: RW];
		item_s3.fm            <= fm_s2;
	end

	assign push      = v_s3;
	assign push_item = item_s3;
	assign inflight  = 2'(v_s1) + 2'(v_s2) + 2'(v_s3);

endmodule

@@ rtl/pffs_isqrt.sv @@
// pipelined floor square root, one result bit per stage
module pffs_isqrt (
	input  logic                             clk,
	input  logic                             en,
	input  logic [pffs_pkg::DSQ_W-1:0]       val,
	output logic [pffs_pkg::ROOT_W-1:0]      root
);
	import pffs_pkg::*;

	logic [DSQ_W-1:0] v_q   [SQRT_STAGES];
	logic [DSQ_W-1:0] res_q [SQRT_STAGES];

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_st
		localparam logic [DSQ_W-1:0] BIT = DSQ_W'(1) << (DSQ_W - 2 - 2 * j);
		logic [DSQ_W-1:0] v_in, r_in, trial;
		if (j == 0) begin : g_first
			assign v_in = val;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_q[j-1];
			assign r_in = res_q[j-1];
		end
		assign trial = r_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in >= trial) begin
					v_q[j]   <= v_in - trial;
					res_q[j] <= (r_in >> 1) + BIT;
				end else begin
					v_q[j]   <= v_in;
					res_q[j] <= r_in >> 1;
				end
			end
		end
	end

	assign root = res_q[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

@@ rtl/pffs_div.sv @@
// pipelined restoring divider; the first stage sets the saturation flag, each later stage one quotient bit
module pffs_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [pffs_pkg::NUM_W-1:0]   num,
	input  logic [pffs_pkg::DSQ_W-1:0]   den,
	output logic                         ovf,
	output logic [pffs_pkg::Q_W-1:0]     quo
);
	import pffs_pkg::*;

	localparam int CMP_W = DSQ_W + Q_W;

	logic [NUM_W-1:0] rem_q [DIV_STAGES];
	logic [DSQ_W-1:0] den_q [DIV_STAGES];
	logic             ovf_q [DIV_STAGES];
	logic [Q_W-1:0]   quo_q [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= num;
			den_q[0] <= den;
			ovf_q[0] <= CMP_W'(num) >= (CMP_W'(den) << Q_W);
			quo_q[0] <= '0;
		end
	end

	for (genvar j = 1; j < DIV_STAGES; j++) begin : g_st
		localparam int B = Q_W - j;
		logic [CMP_W-1:0] sh;
		logic             ge;
		assign sh = CMP_W'(den_q[j-1]) << B;
		assign ge = CMP_W'(rem_q[j-1]) >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= ge ? NUM_W'(CMP_W'(rem_q[j-1]) - sh) : rem_q[j-1];
				den_q[j] <= den_q[j-1];
				ovf_q[j] <= ovf_q[j-1];
				quo_q[j] <= quo_q[j-1] | (Q_W'(ge) << B);
			end
		end
	end

	assign ovf = ovf_q[DIV_STAGES-1];
	assign quo = quo_q[DIV_STAGES-1];

endmodule

@@ rtl/pffs_back.sv @@
// back part: force magnitude through divider (by the square root of the distance in linear mode), result register
module pffs_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pffs_pkg::item_t                head,
	input  logic                           head_valid,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           affected,
	output logic signed [pffs_pkg::DW-1:0] force_x,
	output logic signed [pffs_pkg::DW-1:0] force_y,
	output logic signed [pffs_pkg::DW-1:0] new_vel_x,
	output logic signed [pffs_pkg::DW-1:0] new_vel_y,
	output logic signed [pffs_pkg::DW-1:0] new_ang_vel
);
	import pffs_pkg::*;

	typedef struct packed {
		side_t             side;
		logic              mode;
		logic [PROD_W-1:0] num_x;
		logic [PROD_W-1:0] num_y;
		logic [DSQ_W-1:0]  dsq;
	} l1_t;

	function automatic logic [DW-1:0] pack_force(input logic neg, input logic ovf,
		input logic [Q_W-1:0] q);
		logic [DW-1:0] r;
		if (ovf)
			r = neg ? SAT_NEG : SAT_POS;
		else
			r = neg ? DW'(-{1'b0, q}) : {1'b0, q};
		return r;
	endfunction

	logic              adv;
	logic [DW-1:0]     mul_op;
	logic              v_s1, v_s2;
	l1_t               st_s1;
	l1_t               l1_q  [SQRT_STAGES];
	logic              l1v_q [SQRT_STAGES];
	logic [ROOT_W-1:0] len;
	logic [NUM_W-1:0]  nx_s2, ny_s2;
	logic [DSQ_W-1:0]  den_s2;
	side_t             side_s2;
	side_t             l2_q  [DIV_STAGES];
	logic              l2v_q [DIV_STAGES];
	logic              ovf_x, ovf_y;
	logic [Q_W-1:0]    quo_x, quo_y;
	logic              out_valid_q;
	side_t             last;

	assign adv    = !out_valid_q || out_ready;
	assign pop    = adv && head_valid;
	assign mul_op = head.mode ? {1'b0, head.q} : head.fm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			l1v_q       <= '{default: 1'b0};
			l2v_q       <= '{default: 1'b0};
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1     <= head_valid;
			l1v_q[0] <= v_s1;
			for (int i = 1; i < SQRT_STAGES; i++)
				l1v_q[i] <= l1v_q[i-1];
			v_s2     <= l1v_q[SQRT_STAGES-1];
			l2v_q[0] <= v_s2;
			for (int i = 1; i < DIV_STAGES; i++)
				l2v_q[i] <= l2v_q[i-1];
			out_valid_q <= l2v_q[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1.side  <= head.side;
			st_s1.mode  <= head.mode;
			st_s1.num_x <= head.ax * mul_op;
			st_s1.num_y <= head.ay * mul_op;
			st_s1.dsq   <= head.dsq;
			l1_q[0]     <= st_s1;
			for (int i = 1; i < SQRT_STAGES; i++)
				l1_q[i] <= l1_q[i-1];
		end
	end

	pffs_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.val  (st_s1.dsq),
		.root (len)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= l1_q[SQRT_STAGES-1].side;
			if (l1_q[SQRT_STAGES-1].mode) begin
				nx_s2  <= {l1_q[SQRT_STAGES-1].num_x, {FRAC_BITS{1'b0}}};
				ny_s2  <= {l1_q[SQRT_STAGES-1].num_y, {FRAC_BITS{1'b0}}};
				den_s2 <= l1_q[SQRT_STAGES-1].dsq;
			end else begin
				nx_s2  <= NUM_W'(l1_q[SQRT_STAGES-1].num_x);
				ny_s2  <= NUM_W'(l1_q[SQRT_STAGES-1].num_y);
				den_s2 <= (len == '0) ? DSQ_W'(1) : DSQ_W'(len);
			end
			l2_q[0] <= side_s2;
			for (int i = 1; i < DIV_STAGES; i++)
				l2_q[i] <= l2_q[i-1];
		end
	end

	pffs_div u_div_x (
		.clk (clk),
		.en  (adv),
		.num (nx_s2),
		.den (den_s2),
		.ovf (ovf_x),
		.quo (quo_x)
	);

	pffs_div u_div_y (
		.clk (clk),
		.en  (adv),
		.num (ny_s2),
		.den (den_s2),
		.ovf (ovf_y),
		.quo (quo_y)
	);

	assign last = l2_q[DIV_STAGES-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			affected    <= last.affected;
			force_x     <= last.affected ? pack_force(last.neg_x, ovf_x, quo_x) : '0;
			force_y     <= last.affected ? pack_force(last.neg_y, ovf_y, quo_y) : '0;
			new_vel_x   <= last.vel_x;
			new_vel_y   <= last.vel_y;
			new_ang_vel <= last.vel_a;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/point_force_field_step.sv @@
// top level of the point force field step
//
// One body enters per beat on the in channel (valid/ready); one result beat
// leaves per body on the out channel, in the order taken. Field settings are
// written through the cfg channel (index, data), which is always ready; write
// them only while no body is in flight.
// On its way to the out channel a body passes three classify stages, one
// queue slot, one multiply stage, 32 square root stages, one operand stage,
// 32 divider stages and the output register, the first of them loaded at
// its accepting edge. The square root and divider are fully pipelined, so
// one body per cycle flows while the receiver takes results every cycle.
// When the receiver stalls, the back pipeline holds and the front keeps
// accepting until the queue plus the classify stages fill; in_ready then drops
// and rises again once the back part advances and pops the queue.
// Reset clears the queue, all valid flags and loads the field settings with
// their defaults: radius 1.0, force 0, nonlinear mode on, drag and time 0.
module point_force_field_step #(
	parameter int FIFO_DEPTH = pffs_pkg::FIFO_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [pffs_pkg::DW-1:0] body_x,
	input  logic signed [pffs_pkg::DW-1:0] body_y,
	input  logic signed [pffs_pkg::DW-1:0] lin_vel_x,
	input  logic signed [pffs_pkg::DW-1:0] lin_vel_y,
	input  logic signed [pffs_pkg::DW-1:0] ang_vel,
	input  logic                           is_static,
	input  logic                           is_tracked,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           affected,
	output logic signed [pffs_pkg::DW-1:0] force_x,
	output logic signed [pffs_pkg::DW-1:0] force_y,
	output logic signed [pffs_pkg::DW-1:0] new_vel_x,
	output logic signed [pffs_pkg::DW-1:0] new_vel_y,
	output logic signed [pffs_pkg::DW-1:0] new_ang_vel,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [2:0]                     cfg_index,
	input  logic [pffs_pkg::DW-1:0]        cfg_data
);
	import pffs_pkg::*;

	localparam int CW = $clog2(FIFO_DEPTH + 1);

	cfg_t          cfg_q;
	logic          in_fire;
	logic          push, pop, head_valid;
	item_t         push_item, head;
	logic [1:0]    inflight;
	logic [CW-1:0] count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x          <= '0;
			cfg_q.center_y          <= '0;
			cfg_q.field_radius      <= RADIUS_RESET;
			cfg_q.field_force       <= '0;
			cfg_q.nonlinear_mode    <= 1'b1;
			cfg_q.linear_drag_coef  <= '0;
			cfg_q.angular_drag_coef <= '0;
			cfg_q.frame_time        <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_CENTER_X:       cfg_q.center_x          <= cfg_data;
				REG_CENTER_Y:       cfg_q.center_y          <= cfg_data;
				REG_FIELD_RADIUS:   cfg_q.field_radius      <= cfg_data[RW-1:0];
				REG_FIELD_FORCE:    cfg_q.field_force       <= cfg_data;
				REG_NONLINEAR_MODE: cfg_q.nonlinear_mode    <= cfg_data[0];
				REG_LINEAR_DRAG:    cfg_q.linear_drag_coef  <= cfg_data;
				REG_ANGULAR_DRAG:   cfg_q.angular_drag_coef <= cfg_data;
				REG_FRAME_TIME:     cfg_q.frame_time        <= cfg_data[RW-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = ((CW+1)'(count) + (CW+1)'(inflight)) < (CW+1)'(FIFO_DEPTH);
	assign in_fire  = in_valid && in_ready;

	pffs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_fire    (in_fire),
		.body_x     (body_x),
		.body_y     (body_y),
		.lin_vel_x  (lin_vel_x),
		.lin_vel_y  (lin_vel_y),
		.ang_vel    (ang_vel),
		.is_static  (is_static),
		.is_tracked (is_tracked),
		.push       (push),
		.push_item  (push_item),
		.inflight   (inflight)
	);

	pffs_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.count      (count)
	);

	pffs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.affected    (affected),
		.force_x     (force_x),
		.force_y     (force_y),
		.new_vel_x   (new_vel_x),
		.new_vel_y   (new_vel_y),
		.new_ang_vel (new_ang_vel)
	);

endmodule
